// ===== design/tekd_pkg.sv =====
package tekd_pkg;

	localparam int DIGIT_BUFFER_DEF = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] ESC_BYTE   = 8'h1b;
	localparam logic [7:0] CHAR_O     = 8'h4f;
	localparam logic [7:0] CHAR_LBR   = 8'h5b;
	localparam logic [7:0] CHAR_TILDE = 8'h7e;
	localparam logic [7:0] CHAR_SEMI  = 8'h3b;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] NO_KEY     = 8'hff;

	localparam logic [7:0] KEY_UP    = 8'd0;
	localparam logic [7:0] KEY_DOWN  = 8'd1;
	localparam logic [7:0] KEY_RIGHT = 8'd2;
	localparam logic [7:0] KEY_LEFT  = 8'd3;
	localparam logic [7:0] KEY_LINE_HOME = 8'd4;
	localparam logic [7:0] KEY_END   = 8'd5;
	localparam logic [7:0] KEY_DEL   = 8'd6;
	localparam logic [7:0] KEY_PGUP  = 8'd7;
	localparam logic [7:0] KEY_PGDN  = 8'd8;
	localparam logic [7:0] KEY_F1    = 8'd9;
	localparam logic [7:0] KEY_F5    = 8'd13;
	localparam logic [7:0] KEY_F6    = 8'd14;
	localparam logic [7:0] KEY_F11   = 8'd19;
	localparam logic [7:0] KEY_PASTE_ON  = 8'd21;
	localparam logic [7:0] KEY_PASTE_OFF = 8'd22;

	// One classified input byte as it travels from the front to the back.
	typedef struct packed {
		logic       timeout;
		logic [7:0] byte_val;
		logic       is_esc;
		logic       is_o;
		logic       is_lbr;
		logic       is_tilde;
		logic       is_semi;
		logic       is_digit;
		logic [3:0] digit;
		logic [7:0] letter_key;  // arrow/home/end code after CSI, or NO_KEY
		logic [7:0] ss3_key;     // key code after SS3, or NO_KEY
		logic [2:0] mod_flags;   // {ctrl, meta, shift}, zero outside '2'..'8'
	} tok_t;

	function automatic logic [7:0] csi_number(input logic [7:0] n);
		logic [7:0] k;
		unique case (n) inside
			8'd3:            k = KEY_DEL;
			8'd5:            k = KEY_PGUP;
			8'd6:            k = KEY_PGDN;
			[8'd11:8'd14]:   k = KEY_F1 + (n - 8'd11);
			8'd15:           k = KEY_F5;
			[8'd17:8'd21]:   k = KEY_F6 + (n - 8'd17);
			[8'd23:8'd24]:   k = KEY_F11 + (n - 8'd23);
			8'd200:          k = KEY_PASTE_ON;
			8'd201:          k = KEY_PASTE_OFF;
			default:         k = NO_KEY;
		endcase
		return k;
	endfunction

endpackage

// ===== design/tekd_front.sv =====
module tekd_front (
	input  logic              operation,
	input  logic [7:0]        byte_value,
	output tekd_pkg::tok_t    tok
);

	logic [7:0] mod_m;

	assign mod_m = byte_value - tekd_pkg::CHAR_ONE;

	always_comb begin
		tok.timeout  = operation;
		tok.byte_val = byte_value;
		tok.is_esc   = (byte_value == tekd_pkg::ESC_BYTE);
		tok.is_o     = (byte_value == tekd_pkg::CHAR_O);
		tok.is_lbr   = (byte_value == tekd_pkg::CHAR_LBR);
		tok.is_tilde = (byte_value == tekd_pkg::CHAR_TILDE);
		tok.is_semi  = (byte_value == tekd_pkg::CHAR_SEMI);
		tok.is_digit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
		tok.digit    = 4'(byte_value - tekd_pkg::CHAR_ZERO);

		unique case (byte_value)
			8'h41:   tok.letter_key = tekd_pkg::KEY_UP;
			8'h42:   tok.letter_key = tekd_pkg::KEY_DOWN;
			8'h43:   tok.letter_key = tekd_pkg::KEY_RIGHT;
			8'h44:   tok.letter_key = tekd_pkg::KEY_LEFT;
			8'h48:   tok.letter_key = tekd_pkg::KEY_LINE_HOME;
			8'h46:   tok.letter_key = tekd_pkg::KEY_END;
			default: tok.letter_key = tekd_pkg::NO_KEY;
		endcase

		unique case (byte_value)
			8'h50:   tok.ss3_key = tekd_pkg::KEY_F1;
			8'h51:   tok.ss3_key = tekd_pkg::KEY_F1 + 8'd1;
			8'h52:   tok.ss3_key = tekd_pkg::KEY_F1 + 8'd2;
			8'h53:   tok.ss3_key = tekd_pkg::KEY_F1 + 8'd3;
			8'h48:   tok.ss3_key = tekd_pkg::KEY_LINE_HOME;
			8'h46:   tok.ss3_key = tekd_pkg::KEY_END;
			default: tok.ss3_key = tekd_pkg::NO_KEY;
		endcase

		// Modifier digits '2'..'8' map to a bitmask of one less.
		if ((byte_value >= 8'h32) && (byte_value <= 8'h38)) begin
			tok.mod_flags = mod_m[2:0];
		end else begin
			tok.mod_flags = 3'b000;
		end
	end

endmodule

// ===== design/tekd_queue.sv =====
module tekd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tekd_pkg::tok_t push_tok,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output tekd_pkg::tok_t head_tok
);

	localparam int DEPTH = tekd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tekd_pkg::tok_t     store_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head_tok  = store_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/tekd_back.sv =====
module tekd_back #(
	parameter int DIGIT_BUFFER = tekd_pkg::DIGIT_BUFFER_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  tekd_pkg::tok_t tok,
	output logic           tok_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           is_special,
	output logic [7:0]     key_code,
	output logic           shift_flag,
	output logic           meta_flag,
	output logic           ctrl_flag
);

	localparam int CNT_W = $clog2(DIGIT_BUFFER);
	localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(DIGIT_BUFFER - 1);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_SS3    = 3'd2;
	localparam logic [2:0] PH_CSI    = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_MOD    = 3'd5;
	localparam logic [2:0] PH_TERM   = 3'd6;

	logic [2:0]       phase_q, phase_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [7:0]       number_q, number_nxt;
	logic [2:0]       mod_q, mod_nxt;

	logic             out_valid_q;
	logic             res_special_q;
	logic [7:0]       res_code_q;
	logic [2:0]       res_flags_q;

	logic             emit;
	logic             emit_special;
	logic [7:0]       emit_code;
	logic [2:0]       emit_flags;
	logic [11:0]      number_acc;
	logic [CNT_W:0]   count_inc;
	logic [7:0]       term_key;
	logic [7:0]       tilde_key;

	// The output register frees itself when its transaction completes.
	assign tok_pop = tok_valid && (!out_valid_q || out_ready);

	assign number_acc = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0}
		+ {8'd0, tok.digit};
	assign count_inc  = {1'b0, count_q} + 1'b1;
	assign tilde_key  = tekd_pkg::csi_number(number_q);

	always_comb begin
		if (number_q == 8'd1) begin
			term_key = tok.letter_key;
		end else if (tok.is_tilde) begin
			term_key = tilde_key;
		end else begin
			term_key = tekd_pkg::NO_KEY;
		end
	end

	always_comb begin
		phase_nxt    = phase_q;
		count_nxt    = count_q;
		number_nxt   = number_q;
		mod_nxt      = mod_q;
		emit         = 1'b0;
		emit_special = 1'b0;
		emit_code    = tekd_pkg::ESC_BYTE;
		emit_flags   = 3'b000;

		unique case (phase_q)
			PH_ESC: begin
				if (tok.timeout) begin
					emit = 1'b1;
				end else if (tok.is_o) begin
					phase_nxt = PH_SS3;
				end else if (tok.is_lbr) begin
					phase_nxt = PH_CSI;
				end else begin
					emit       = 1'b1;
					emit_code  = tok.byte_val;
					emit_flags = 3'b010;
				end
			end
			PH_SS3: begin
				if (tok.timeout) begin
					emit       = 1'b1;
					emit_code  = tekd_pkg::CHAR_O;
					emit_flags = 3'b010;
				end else if (tok.ss3_key != tekd_pkg::NO_KEY) begin
					emit         = 1'b1;
					emit_special = 1'b1;
					emit_code    = tok.ss3_key;
				end else begin
					emit = 1'b1;
				end
			end
			PH_CSI: begin
				if (tok.timeout) begin
					emit = 1'b1;
				end else if (tok.is_digit) begin
					number_nxt = {4'd0, tok.digit};
					count_nxt  = CNT_W'(1);
					if (CNT_LIMIT <= (CNT_W + 1)'(1)) begin
						emit = 1'b1;
					end else begin
						phase_nxt = PH_DIGITS;
					end
				end else if (tok.letter_key != tekd_pkg::NO_KEY) begin
					emit         = 1'b1;
					emit_special = 1'b1;
					emit_code    = tok.letter_key;
				end else begin
					emit = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (tok.timeout) begin
					emit = 1'b1;
				end else if (tok.is_digit) begin
					number_nxt = (number_acc > 12'd255) ? 8'd255 : number_acc[7:0];
					count_nxt  = count_inc[CNT_W-1:0];
					if (count_inc >= CNT_LIMIT) begin
						emit = 1'b1;
					end
				end else if (tok.is_tilde) begin
					emit = 1'b1;
					if (tilde_key != tekd_pkg::NO_KEY) begin
						emit_special = 1'b1;
						emit_code    = tilde_key;
					end
				end else if (tok.is_semi) begin
					phase_nxt = PH_MOD;
				end else begin
					emit = 1'b1;
				end
			end
			PH_MOD: begin
				if (tok.timeout) begin
					emit = 1'b1;
				end else begin
					mod_nxt   = tok.mod_flags;
					phase_nxt = PH_TERM;
				end
			end
			PH_TERM: begin
				emit = 1'b1;
				if (!tok.timeout && (term_key != tekd_pkg::NO_KEY)) begin
					emit_special = 1'b1;
					emit_code    = term_key;
					emit_flags   = mod_q;
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
				if (!tok.timeout) begin
					if (tok.is_esc) begin
						phase_nxt = PH_ESC;
					end else begin
						emit      = 1'b1;
						emit_code = tok.byte_val;
					end
				end
			end
		endcase

		if (emit) begin
			phase_nxt = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			number_q    <= '0;
			mod_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop) begin
				phase_q  <= phase_nxt;
				count_q  <= count_nxt;
				number_q <= number_nxt;
				mod_q    <= mod_nxt;
			end
			if (tok_pop) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && emit) begin
			res_special_q <= emit_special;
			res_code_q    <= emit_code;
			res_flags_q   <= emit_flags;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_special = res_special_q;
	assign key_code   = res_code_q;
	assign shift_flag = res_flags_q[0];
	assign meta_flag  = res_flags_q[1];
	assign ctrl_flag  = res_flags_q[2];

endmodule

// ===== design/terminal_escape_key_decoder_top.sv =====
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | operation, byte_value
// output  | out_valid / out_ready| is_special, key_code, shift_flag, meta_flag, ctrl_flag
//
// One transaction per cycle sustained while the output drains; a byte's result passes
// through the queue write, then one parser step, into the output register.
// The parser state machine retires one queued byte per cycle whenever the output
// register is empty or being drained; the two-entry queue keeps input flowing meanwhile.
// Reset clears the parser state, the queue and the output valid; no clearing pass.
// Stalls on the output back up into the queue, then drop in_ready when it is full.
module terminal_escape_key_decoder_top #(
	parameter int DIGIT_BUFFER = tekd_pkg::DIGIT_BUFFER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_special,
	output logic [7:0] key_code,
	output logic       shift_flag,
	output logic       meta_flag,
	output logic       ctrl_flag
);

	tekd_pkg::tok_t in_tok;
	tekd_pkg::tok_t head_tok;
	logic           head_valid;
	logic           head_pop;

	tekd_front u_front (
		.operation  (operation),
		.byte_value (byte_value),
		.tok        (in_tok)
	);

	tekd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_tok  (in_tok),
		.not_full  (in_ready),
		.pop       (head_pop),
		.not_empty (head_valid),
		.head_tok  (head_tok)
	);

	tekd_back #(
		.DIGIT_BUFFER (DIGIT_BUFFER)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (head_valid),
		.tok        (head_tok),
		.tok_pop    (head_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_special (is_special),
		.key_code   (key_code),
		.shift_flag (shift_flag),
		.meta_flag  (meta_flag),
		.ctrl_flag  (ctrl_flag)
	);

endmodule

// ===== tb/sv/terminal_escape_key_decoder_top_tb.sv =====
module terminal_escape_key_decoder_top_tb;

	localparam int DIGIT_LIMIT  = tekd_pkg::DIGIT_BUFFER_DEF;
	localparam int STUCK_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1310;
	localparam int DRAIN_CYCLES = 20;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_SS3    = 3'd2;
	localparam logic [2:0] PH_CSI    = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_MOD    = 3'd5;
	localparam logic [2:0] PH_TERM   = 3'd6;

	typedef struct packed {
		logic       is_special;
		logic [7:0] code;
		logic       shift;
		logic       meta;
		logic       ctrl;
	} key_result_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} key_input_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       operation;
	logic [7:0] byte_value;
	logic       out_valid;
	logic       out_ready;
	logic       is_special;
	logic [7:0] key_code;
	logic       shift_flag;
	logic       meta_flag;
	logic       ctrl_flag;

	// Decoder state as the testbench tracks it.
	logic [2:0]   dec_phase  = PH_IDLE;
	int           dec_digits = 0;
	logic [7:0]   dec_number = 8'd0;
	logic [7:0]   dec_mod    = 8'd0;

	key_result_t expected_keys[$];
	int          errors       = 0;
	int          items_sent   = 0;
	int          burst_left   = 0;
	int          stuck_cycles = 0;
	bit          hold_request = 1'b0;

	int csi_codes[18] = '{1, 3, 5, 6, 11, 12, 13, 14, 15, 17, 18, 19, 20, 21, 23, 24,
		200, 201};

	terminal_escape_key_decoder_top #(
		.DIGIT_BUFFER(DIGIT_LIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.byte_value(byte_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_special(is_special),
		.key_code  (key_code),
		.shift_flag(shift_flag),
		.meta_flag (meta_flag),
		.ctrl_flag (ctrl_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic is_dec_digit(input logic [7:0] b);
		return b >= tekd_pkg::CHAR_ZERO && b <= "9";
	endfunction

	function automatic logic [7:0] arrow_key(input logic [7:0] b);
		case (b)
			"A":     return tekd_pkg::KEY_UP;
			"B":     return tekd_pkg::KEY_DOWN;
			"C":     return tekd_pkg::KEY_RIGHT;
			"D":     return tekd_pkg::KEY_LEFT;
			"H":     return tekd_pkg::KEY_LINE_HOME;
			"F":     return tekd_pkg::KEY_END;
			default: return tekd_pkg::NO_KEY;
		endcase
	endfunction

	function automatic logic [7:0] tilde_key(input logic [7:0] n);
		if (n == 8'd3) return tekd_pkg::KEY_DEL;
		if (n == 8'd5) return tekd_pkg::KEY_PGUP;
		if (n == 8'd6) return tekd_pkg::KEY_PGDN;
		if (n >= 8'd11 && n <= 8'd14) return tekd_pkg::KEY_F1 + (n - 8'd11);
		if (n == 8'd15) return tekd_pkg::KEY_F5;
		if (n >= 8'd17 && n <= 8'd21) return tekd_pkg::KEY_F6 + (n - 8'd17);
		if (n == 8'd23 || n == 8'd24) return tekd_pkg::KEY_F11 + (n - 8'd23);
		if (n == 8'd200) return tekd_pkg::KEY_PASTE_ON;
		if (n == 8'd201) return tekd_pkg::KEY_PASTE_OFF;
		return tekd_pkg::NO_KEY;
	endfunction

	task automatic emit_key(input logic special, input logic [7:0] code,
			input logic sh, input logic me, input logic ct);
		expected_keys.push_back({special, code, sh, me, ct});
		dec_phase = PH_IDLE;
	endtask

	task automatic emit_bare_esc();
		emit_key(1'b0, tekd_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic advance_decoder(input key_input_t it);
		logic [7:0] k;
		logic [7:0] m;
		int         v;
		logic       tmo;
		tmo = (it.op == OP_TIMEOUT);
		case (dec_phase)
			PH_ESC: begin
				if (tmo)
					emit_bare_esc();
				else if (it.data == tekd_pkg::CHAR_O)
					dec_phase = PH_SS3;
				else if (it.data == tekd_pkg::CHAR_LBR)
					dec_phase = PH_CSI;
				else
					emit_key(1'b0, it.data, 1'b0, 1'b1, 1'b0);
			end
			PH_SS3: begin
				// A timeout here means the O was a meta keystroke after all.
				if (tmo) begin
					emit_key(1'b0, tekd_pkg::CHAR_O, 1'b0, 1'b1, 1'b0);
				end else begin
					case (it.data)
						"P", "Q", "R", "S": k = tekd_pkg::KEY_F1 + (it.data - "P");
						"H":                k = tekd_pkg::KEY_LINE_HOME;
						"F":                k = tekd_pkg::KEY_END;
						default:            k = tekd_pkg::NO_KEY;
					endcase
					if (k == tekd_pkg::NO_KEY)
						emit_bare_esc();
					else
						emit_key(1'b1, k, 1'b0, 1'b0, 1'b0);
				end
			end
			PH_CSI: begin
				if (tmo) begin
					emit_bare_esc();
				end else if (is_dec_digit(it.data)) begin
					dec_number = it.data - tekd_pkg::CHAR_ZERO;
					dec_digits = 1;
					if (dec_digits >= DIGIT_LIMIT - 1)
						emit_bare_esc();
					else
						dec_phase = PH_DIGITS;
				end else begin
					k = arrow_key(it.data);
					if (k == tekd_pkg::NO_KEY)
						emit_bare_esc();
					else
						emit_key(1'b1, k, 1'b0, 1'b0, 1'b0);
				end
			end
			PH_DIGITS: begin
				if (tmo) begin
					emit_bare_esc();
				end else if (is_dec_digit(it.data)) begin
					v = dec_number * 10 + (it.data - tekd_pkg::CHAR_ZERO);
					dec_number = (v > 255) ? 8'd255 : v[7:0];
					dec_digits++;
					if (dec_digits >= DIGIT_LIMIT - 1)
						emit_bare_esc();
				end else if (it.data == tekd_pkg::CHAR_TILDE) begin
					k = tilde_key(dec_number);
					if (k == tekd_pkg::NO_KEY)
						emit_bare_esc();
					else
						emit_key(1'b1, k, 1'b0, 1'b0, 1'b0);
				end else if (it.data == tekd_pkg::CHAR_SEMI) begin
					dec_phase = PH_MOD;
				end else begin
					emit_bare_esc();
				end
			end
			PH_MOD: begin
				if (tmo) begin
					emit_bare_esc();
				end else begin
					dec_mod = it.data;
					dec_phase = PH_TERM;
				end
			end
			PH_TERM: begin
				if (tmo) begin
					emit_bare_esc();
				end else begin
					if (dec_number == 8'd1)
						k = arrow_key(it.data);
					else if (it.data == tekd_pkg::CHAR_TILDE)
						k = tilde_key(dec_number);
					else
						k = tekd_pkg::NO_KEY;
					if (k == tekd_pkg::NO_KEY) begin
						emit_bare_esc();
					end else if (dec_mod >= "2" && dec_mod <= "8") begin
						// The modifier digit minus one is a {ctrl, meta, shift} mask.
						m = dec_mod - tekd_pkg::CHAR_ONE;
						emit_key(1'b1, k, m[0], m[1], m[2]);
					end else begin
						emit_key(1'b1, k, 1'b0, 1'b0, 1'b0);
					end
				end
			end
			default: begin
				dec_phase = PH_IDLE;
				if (!tmo) begin
					if (it.data == tekd_pkg::ESC_BYTE)
						dec_phase = PH_ESC;
					else
						emit_key(1'b0, it.data, 1'b0, 1'b0, 1'b0);
				end
			end
		endcase
	endtask

	// Offers one input transaction and returns at the edge that accepts it.
	task automatic send_key_input(input key_input_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		operation  <= it.op;
		byte_value <= it.data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		advance_decoder(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_key_input({OP_BYTE, b});
	endtask

	// The byte lane carries random junk on a timeout.
	task automatic send_timeout();
		send_key_input({OP_TIMEOUT, 8'($urandom_range(0, 255))});
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_esc_text(input string s);
		send_byte(tekd_pkg::ESC_BYTE);
		send_text(s);
	endtask

	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_keys.size() != 0) @(posedge clk);
	endtask

	task automatic test_plain_keys();
		send_byte(8'h00);
		send_byte(8'hff);
		send_timeout();
		send_text("a");
	endtask

	task automatic test_meta_and_ss3();
		send_byte(tekd_pkg::ESC_BYTE);
		send_timeout();
		send_esc_text("x");
		send_byte(tekd_pkg::ESC_BYTE);
		send_byte(tekd_pkg::ESC_BYTE);
		send_esc_text("O");
		send_timeout();
		send_esc_text("OP");
		send_esc_text("OS");
		send_esc_text("OZ");
	endtask

	task automatic test_csi_keys();
		send_esc_text("[A");
		send_esc_text("[F");
		send_esc_text("[Z");
		send_esc_text("[");
		send_timeout();
		send_esc_text("[3~");
		send_esc_text("[24~");
		send_esc_text("[201~");
		// Saturates at 255, which is no key.
		send_esc_text("[999~");
		send_esc_text("[2~");
		send_esc_text("[1234567");
		send_esc_text("[1;5A");
		send_esc_text("[6;8~");
		send_esc_text("[1;9D");
		send_esc_text("[5;2A");
		send_esc_text("[4x");
		send_esc_text("[1;");
		send_timeout();
	endtask

	// The receiver holds off while plain bytes keep coming, so the block backs up.
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (40) send_byte(8'($urandom_range(32, 126)));
		wait_drained();
	endtask

	function automatic int pick_csi_number();
		case ($urandom_range(0, 5))
			4:       return $urandom_range(0, 300);
			5:       return $urandom_range(0, 9999999);
			default: return csi_codes[$urandom_range(0, 17)];
		endcase
	endfunction

	task automatic push_number(ref key_input_t seq[$], input int n);
		string digits;
		digits = $sformatf("%0d", n);
		if ($urandom_range(0, 9) == 0) digits = {"0", digits};
		for (int i = 0; i < digits.len(); i++) seq.push_back({OP_BYTE, digits[i]});
	endtask

	task automatic send_random_sequence();
		key_input_t seq[$];
		string      arrows;
		string      ss3_keys;
		int         n;
		int         idx;
		logic [7:0] b;
		arrows   = "ABCDHF";
		ss3_keys = "PQRSHF";
		b = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0, 1: seq.push_back({OP_BYTE, b});
			2: seq.push_back({logic'($urandom_range(0, 1)), b});
			3: begin
				seq.push_back({OP_BYTE, tekd_pkg::ESC_BYTE});
				seq.push_back({logic'($urandom_range(0, 7) == 0), b});
			end
			4: begin
				seq.push_back({OP_BYTE, tekd_pkg::ESC_BYTE});
				seq.push_back({OP_BYTE, tekd_pkg::CHAR_O});
				if ($urandom_range(0, 4) != 0) b = ss3_keys[$urandom_range(0, 5)];
				seq.push_back({OP_BYTE, b});
			end
			5: begin
				seq.push_back({OP_BYTE, tekd_pkg::ESC_BYTE});
				seq.push_back({OP_BYTE, tekd_pkg::CHAR_LBR});
				if ($urandom_range(0, 4) != 0) b = arrows[$urandom_range(0, 5)];
				seq.push_back({OP_BYTE, b});
			end
			6, 7: begin
				seq.push_back({OP_BYTE, tekd_pkg::ESC_BYTE});
				seq.push_back({OP_BYTE, tekd_pkg::CHAR_LBR});
				push_number(seq, pick_csi_number());
				if ($urandom_range(0, 7) != 0) b = tekd_pkg::CHAR_TILDE;
				seq.push_back({OP_BYTE, b});
			end
			default: begin
				n = ($urandom_range(0, 1) == 0) ? 1 : pick_csi_number();
				seq.push_back({OP_BYTE, tekd_pkg::ESC_BYTE});
				seq.push_back({OP_BYTE, tekd_pkg::CHAR_LBR});
				push_number(seq, n);
				seq.push_back({OP_BYTE, tekd_pkg::CHAR_SEMI});
				if ($urandom_range(0, 5) != 0)
					seq.push_back({OP_BYTE, 8'($urandom_range(8'h32, 8'h38))});
				else
					seq.push_back({OP_BYTE, 8'($urandom_range(0, 255))});
				if ($urandom_range(0, 7) != 0)
					b = (n == 1) ? arrows[$urandom_range(0, 5)] : tekd_pkg::CHAR_TILDE;
				seq.push_back({OP_BYTE, b});
			end
		endcase
		// Now and then one transaction of the sequence is replaced by junk or a timeout.
		if (seq.size() > 1 && $urandom_range(0, 7) == 0) begin
			idx = $urandom_range(0, seq.size() - 1);
			seq[idx] = {logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
		end
		foreach (seq[i]) send_key_input(seq[i]);
	endtask

	task automatic test_random_sequences();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) send_random_sequence();
	endtask

	initial begin : rx_pattern
		int mode;
		int span;
		mode = 0;
		span = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 80);
			end
			span--;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (span % 3 != 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : key_checker
		key_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_keys.size() == 0) begin
				errors++;
				$display("%0t: key with none expected: special %0b code %0h flags %0b%0b%0b",
					$time, is_special, key_code, shift_flag, meta_flag, ctrl_flag);
			end else begin
				want = expected_keys.pop_front();
				check_field("is_special", 8'(want.is_special), 8'(is_special));
				check_field("key_code", want.code, key_code);
				check_field("shift_flag", 8'(want.shift), 8'(shift_flag));
				check_field("meta_flag", 8'(want.meta), 8'(meta_flag));
				check_field("ctrl_flag", 8'(want.ctrl), 8'(ctrl_flag));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = OP_BYTE;
		byte_value = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_plain_keys();
		test_meta_and_ss3();
		test_csi_keys();
		test_output_backpressure();
		test_random_sequences();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== terminal_escape_key_decoder_top.f =====
design/tekd_pkg.sv
design/tekd_front.sv
design/tekd_queue.sv
design/tekd_back.sv
design/terminal_escape_key_decoder_top.sv
tb/sv/terminal_escape_key_decoder_top_tb.sv
